@@ hdl/si2d_pkg.sv @@
// Package for the signed 128-bit to decimal digit converter.
// Holds widths and the BCD add-three helper; no dependencies.
package si2d_pkg;

    localparam int WORD_W    = 64;
    localparam int MAG_W     = 128;
    localparam int NDIG      = 39;
    localparam int BCD_W     = NDIG * 4;
    localparam int DIGIT_W   = 4;
    localparam int DIGCNT_W  = 6;
    localparam int BITS_PER_STAGE = 8;
    localparam int NSTAGE    = MAG_W / BITS_PER_STAGE;

    typedef logic [BCD_W-1:0] bcd_t;

    // One double-dabble step: add three to every digit at five or more, then
    // shift in one binary bit.
    function automatic bcd_t dabble_step(input bcd_t b, input logic bit_in);
        bcd_t adj;
        adj = b;
        for (int d = 0; d < NDIG; d++) begin
            if (b[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

endpackage

@@ hdl/si2d_dabble.sv @@
// Pipelined double-dabble converter: eight binary bits per register stage.
// Depends on si2d_pkg.
module si2d_dabble import si2d_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [MAG_W-1:0] in_mag,
    input  logic             in_neg,
    output logic             out_valid,
    input  logic             out_ready,
    output bcd_t             out_bcd,
    output logic             out_neg
);

    logic             vld_reg [NSTAGE+1];
    logic [MAG_W-1:0] mag_reg [NSTAGE+1];
    bcd_t             bcd_reg [NSTAGE+1];
    logic             neg_reg [NSTAGE+1];
    logic             adv [NSTAGE+1];

    // Stage enables: a stage moves when it is empty or the next one moves.
    always_comb begin
        adv[NSTAGE] = !vld_reg[NSTAGE] || out_ready;
        for (int s = NSTAGE - 1; s >= 0; s--) begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NSTAGE];
    assign out_bcd   = bcd_reg[NSTAGE];
    assign out_neg   = neg_reg[NSTAGE];

    // Entry stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv[0]) begin
            vld_reg[0] <= in_valid;
        end
        if (adv[0]) begin
            mag_reg[0] <= in_mag;
            bcd_reg[0] <= '0;
            neg_reg[0] <= in_neg;
        end
    end

    // Conversion stages, each consuming eight magnitude bits.
    for (genvar s = 1; s <= NSTAGE; s++) begin : g_stage
        bcd_t             bcd_next;
        logic [MAG_W-1:0] mag_next;
        always_comb begin
            bcd_next = bcd_reg[s-1];
            mag_next = mag_reg[s-1];
            for (int k = 0; k < BITS_PER_STAGE; k++) begin
                bcd_next = dabble_step(bcd_next, mag_next[MAG_W-1]);
                mag_next = {mag_next[MAG_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (adv[s]) begin
                vld_reg[s] <= vld_reg[s-1];
            end
            if (adv[s]) begin
                mag_reg[s] <= mag_next;
                bcd_reg[s] <= bcd_next;
                neg_reg[s] <= neg_reg[s-1];
            end
        end
    end

endmodule

@@ hdl/signed_int128_to_decimal_digits_top.sv @@
// Signed 128-bit integer to decimal digits, top level.
// Depends on si2d_pkg and si2d_dabble.
//
// An item is accepted in any cycle the 18-stage conversion pipeline has room
// (one negate stage, one entry register, then sixteen double-dabble stages of
// eight bits each). Each item's digits then leave one per cycle from a
// serializer while m_ready is high, 1 to 39 digits per item; the
// serializer takes the next item only once the current item's last digit
// is taken.
module signed_int128_to_decimal_digits_top import si2d_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [WORD_W-1:0]        s_low_word,
    input  logic signed [WORD_W-1:0] s_high_word,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DIGIT_W-1:0]       m_digit,
    output logic                     m_negative,
    output logic                     m_last
);

    logic             nv_reg;
    logic [MAG_W-1:0] mag_reg;
    logic             neg_reg;
    logic             d_ready;
    logic             c_valid;
    logic             c_ready;
    bcd_t             c_bcd;
    logic             c_neg;

    // Negate stage: two's-complement magnitude and sign.
    logic [MAG_W-1:0] raw;
    logic             n_in;
    assign raw  = {s_high_word, s_low_word};
    assign n_in = s_high_word[WORD_W-1];
    assign s_ready = !nv_reg || d_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv_reg <= 1'b0;
        end else if (s_ready) begin
            nv_reg <= s_valid;
        end
        if (s_ready) begin
            mag_reg <= n_in ? (~raw + MAG_W'(1)) : raw;
            neg_reg <= n_in;
        end
    end

    si2d_dabble u_dabble (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (nv_reg),
        .in_ready (d_ready),
        .in_mag   (mag_reg),
        .in_neg   (neg_reg),
        .out_valid(c_valid),
        .out_ready(c_ready),
        .out_bcd  (c_bcd),
        .out_neg  (c_neg)
    );

    // Leading digit index: highest nonzero digit, zero for the value zero.
    logic [DIGCNT_W-1:0] top_idx;
    always_comb begin
        top_idx = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (c_bcd[d*4 +: 4] != 4'd0) begin
                top_idx = DIGCNT_W'(d);
            end
        end
    end

    // Digit serializer.
    logic                busy_reg;
    bcd_t                sh_reg;
    logic [DIGCNT_W-1:0] idx_reg;
    logic                sneg_reg;

    assign c_ready    = !busy_reg || (m_ready && idx_reg == '0);
    assign m_valid    = busy_reg;
    assign m_digit    = sh_reg[BCD_W-1 -: 4];
    assign m_negative = sneg_reg;
    assign m_last     = (idx_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (c_ready) begin
            busy_reg <= c_valid;
        end
        if (c_ready) begin
            sh_reg   <= c_bcd << ((NDIG - 1 - 32'(top_idx)) * 4);
            idx_reg  <= top_idx;
            sneg_reg <= c_neg && (c_bcd != '0);
        end else if (m_ready) begin
            sh_reg  <= sh_reg << 4;
            idx_reg <= idx_reg - DIGCNT_W'(1);
        end
    end

endmodule

@@ hdl/si2d_checker.sv @@
// Port-level checker for the decimal digit converter, bound to the top level.
// Depends on si2d_pkg.
module si2d_checker import si2d_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [DIGIT_W-1:0] m_digit,
    input logic               m_negative,
    input logic               m_last
);

    logic first_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
        end else if (m_valid && m_ready) begin
            first_reg <= m_last;
        end
    end

    // Every digit is decimal.
    a_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_digit <= 4'd9) else $error("digit out of range");

    // A leading digit is nonzero unless it is the only digit.
    a_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && first_reg && !m_last) |-> m_digit != 4'd0)
        else $error("leading zero emitted");

    // Zero is never negative.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && first_reg && m_last && m_digit == 4'd0) |-> !m_negative)
        else $error("negative zero");

    // The sign holds across one item's digits.
    a_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> (m_valid && m_negative == $past(m_negative)))
        else $error("sign changed inside item");

endmodule

bind signed_int128_to_decimal_digits_top si2d_checker u_si2d_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_digit   (m_digit),
    .m_negative(m_negative),
    .m_last    (m_last)
);

@@ test/digit_checker.sv @@
// Checker for the signed 128-bit to decimal digit converter.
// Watches both channels, predicts the digit sequence and compares; uses si2d_pkg.
module digit_checker import si2d_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [WORD_W-1:0]        s_low_word,
    input  logic signed [WORD_W-1:0] s_high_word,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [DIGIT_W-1:0]       m_digit,
    input  logic                     m_negative,
    input  logic                     m_last,
    output int                       fail_count,
    output int                       pending_digits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               negative;
        logic               last;
    } digit_rec_t;

    digit_rec_t expected_digits[$];

    // Convert one signed 128-bit value into its expected digit records.
    task automatic queue_decimal_digits(input logic [WORD_W-1:0] lo,
                                        input logic [WORD_W-1:0] hi);
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic [3:0]       rev[NDIG];
        int               n;
        digit_rec_t       rec;
        mag = {hi, lo};
        neg = hi[WORD_W-1];
        if (neg) begin
            mag = ~mag + 1'b1;
        end
        if (mag == '0) begin
            neg = 1'b0;
        end
        n = 0;
        do begin
            rev[n] = 4'(mag % 10);
            mag = mag / 10;
            n++;
        end while (mag != '0 && n < NDIG);
        for (int k = 0; k < n; k++) begin
            rec.digit = rev[n-1-k];
            rec.negative = neg;
            rec.last = (k == n - 1);
            expected_digits = {expected_digits, rec};
        end
    endtask

    // Predict on every accepted input, compare on every accepted result.
    always @(posedge aclk) begin
        digit_rec_t exp_rec;
        int         errs;
        errs = 0;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_digits.size() == 0) begin
                    $error("unexpected digit %0d", m_digit);
                    errs++;
                end else begin
                    exp_rec = expected_digits.pop_front();
                    if (m_digit !== exp_rec.digit) begin
                        $error("digit: expected %0d, got %0d", exp_rec.digit, m_digit);
                        errs++;
                    end
                    if (m_negative !== exp_rec.negative) begin
                        $error("negative: expected %0d, got %0d",
                               exp_rec.negative, m_negative);
                        errs++;
                    end
                    if (m_last !== exp_rec.last) begin
                        $error("last: expected %0d, got %0d", exp_rec.last, m_last);
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                queue_decimal_digits(s_low_word, s_high_word);
            end
            fail_count <= fail_count + errs;
        end
        pending_digits <= expected_digits.size();
    end
endmodule

@@ test/testbench.sv @@
// Top of the converter testbench: clock, reset, stimulus, stalls and verdict.
// Depends on si2d_pkg, digit_checker and the converter top level.
module testbench import si2d_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 200;
    localparam int IDLE_LIMIT   = 20000;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [WORD_W-1:0]        s_low_word = '0;
    logic signed [WORD_W-1:0] s_high_word = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [DIGIT_W-1:0]       m_digit;
    logic                     m_negative;
    logic                     m_last;
    int                       fail_count;
    int                       pending_digits;
    bit                       hold_output = 1'b0;
    int                       idle_cycles = 0;

    signed_int128_to_decimal_digits_top dut (.*);
    digit_checker checker_inst (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Random 64-bit word.
    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Offer one item after a random gap and wait until it is accepted.
    task automatic send_value(input logic [127:0] v);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_low_word <= v[63:0];
        s_high_word <= v[127:64];
        do @(posedge aclk); while (!s_ready);
    endtask

    // Receiver: random stall per digit, with one long hold-off when asked.
    initial begin
        int stall;
        bit held;
        held = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = $urandom_range(0, 9);
            if (hold_output && !held) begin
                stall = stall + 400;
                held = 1'b1;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Watchdog on cycles with no accepted item on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (aresetn) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [127:0] v;
        int           sel;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed values: zero, +-1, extremes, digit count boundaries.
        send_value(128'd0);
        send_value(128'd1);
        send_value(-128'sd1);
        send_value(128'd9);
        send_value(128'd10);
        send_value(-128'sd10);
        send_value({1'b0, {127{1'b1}}});
        send_value({1'b1, 127'd0});
        send_value({1'b1, 126'd0, 1'b1});
        send_value({64'd0, {64{1'b1}}});
        send_value({{64{1'b1}}, 64'd0});
        send_value({64'd1, 64'd0});
        send_value(128'd99999999999999999999);
        send_value(128'd100000000000000000000);
        send_value(128'h4B3B4CA85A86C47A098A223FFFFFFFFF);
        send_value(128'h4B3B4CA85A86C47A098A224000000000);
        send_value({64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA});

        // Long receiver hold-off while the sender keeps offering items.
        hold_output = 1'b1;
        for (int i = 0; i < 20; i++) begin
            send_value({rand_word(), rand_word()});
        end

        // Random part with sizes spread over every digit count.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) begin
                // Pause the sender until every expected result has come.
                s_valid <= 1'b0;
                @(posedge aclk);
                wait (pending_digits == 0);
            end
            v = {rand_word(), rand_word()};
            sel = $urandom_range(0, 3);
            if (sel == 0) begin
                v = v >> $urandom_range(0, 127);
            end else if (sel == 1) begin
                v = -(v >> $urandom_range(0, 127));
            end
            send_value(v);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending_digits == 0);
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

@@ signed_int128_to_decimal_digits_top.f @@
hdl/si2d_pkg.sv
hdl/si2d_dabble.sv
hdl/signed_int128_to_decimal_digits_top.sv
hdl/si2d_checker.sv
test/digit_checker.sv
test/testbench.sv
